// ===== rtl/fptm_pkg.sv =====
// Shared types and codes for the four-level page table manager.
package fptm_pkg;

	localparam int CNT_W = 11;

	typedef enum logic [1:0] {
		CMD_XLATE = 2'd0,
		CMD_MAP   = 2'd1,
		CMD_UNMAP = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOMAP   = 2'd1,
		ST_NOPAGE  = 2'd2,
		ST_OUTSIDE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_BASE  = 2'd0,
		REG_ROOT  = 2'd1,
		REG_ALLOC = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_CLR,
		S_IDLE,
		S_RD,
		S_CHK,
		S_PGCLR,
		S_LINK,
		S_DONE
	} state_t;

endpackage

// ===== rtl/fptm_ram.sv =====
// Single-port-write, registered-read table store.
module fptm_ram #(
	parameter int AW = 15
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [63:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [63:0]   rdata
);

	logic [63:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/four_level_page_table_manager_unit.sv =====
// Four-level page table manager: translate, map and unmap over a local table store.
// The page tables live in one synchronous RAM of TABLE_PAGES*512 64-bit entries, read
// by a walk sequencer. After reset the block sweeps the whole store to zero, one entry
// per cycle, and takes no command until done; configuration writes are taken throughout.
// A translate or unmap reads one entry per level walked; a map also clears each new
// table, one entry per cycle through the single RAM write port, before linking it.
// A finished result sits in an output register so the next command can be taken.
module four_level_page_table_manager_unit
	import fptm_pkg::*;
#(
	parameter int TABLE_PAGES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [39:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [47:0] virt_addr,
	input  logic [51:0] phys_addr,
	input  logic [11:0] entry_flags,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [51:0] phys_result
);

	localparam int PW = $clog2(TABLE_PAGES);
	localparam int AW = PW + 9;
	localparam int DEPTH = TABLE_PAGES * 512;

	state_t state_q, state_d;

	logic [39:0]      base_q;
	logic [5:0]       root_q;
	logic [6:0]       alloc_q;
	logic [CNT_W-1:0] used_q, used_d;

	logic [1:0]  cmd_q;
	logic [47:0] va_q;
	logic [51:0] pa_q;
	logic [11:0] flags_q;

	logic [1:0]    lv_q, lv_d;
	logic [PW-1:0] page_q, page_d;
	logic [PW-1:0] npage_q, npage_d;
	logic [AW-1:0] clr_q, clr_d;
	logic [1:0]    res_st_q, res_st_d;
	logic [51:0]   res_pa_q, res_pa_d;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [63:0]   mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [63:0]   rd_data;

	logic [8:0]       idx;
	logic [39:0]      diff;
	logic [CNT_W-1:0] next_pg;
	logic [39:0]      new_frame;

	fptm_ram #(.AW(AW)) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(rd_data)
	);

	always_comb begin
		case (lv_q)
			2'd0:    idx = va_q[47:39];
			2'd1:    idx = va_q[38:30];
			2'd2:    idx = va_q[29:21];
			default: idx = va_q[20:12];
		endcase
	end

	assign diff      = rd_data[51:12] - base_q;
	assign next_pg   = CNT_W'(alloc_q) + used_q;
	assign new_frame = base_q + 40'(npage_q);
	assign mem_raddr = {page_q, idx};
	assign in_ready  = (state_q == S_IDLE);

	always_comb begin
		state_d   = state_q;
		used_d    = used_q;
		lv_d      = lv_q;
		page_d    = page_q;
		npage_d   = npage_q;
		clr_d     = clr_q;
		res_st_d  = res_st_q;
		res_pa_d  = res_pa_q;
		mem_we    = 1'b0;
		mem_waddr = {page_q, idx};
		mem_wdata = '0;
		case (state_q)
			S_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				clr_d     = clr_q + 1'b1;
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					res_pa_d = '0;
					lv_d     = 2'd0;
					page_d   = PW'(root_q);
					if (cmd == CMD_NOP) begin
						res_st_d = ST_OK;
						state_d  = S_DONE;
					end else if (CNT_W'(root_q) >= CNT_W'(TABLE_PAGES)) begin
						res_st_d = ST_OUTSIDE;
						state_d  = S_DONE;
					end else begin
						state_d = S_RD;
					end
				end
			end
			S_RD: begin
				state_d = S_CHK;
			end
			S_CHK: begin
				if (lv_q != 2'd3) begin
					if (rd_data[0]) begin
						if (diff >= 40'(TABLE_PAGES)) begin
							res_st_d = ST_OUTSIDE;
							state_d  = S_DONE;
						end else begin
							page_d  = diff[PW-1:0];
							lv_d    = lv_q + 1'b1;
							state_d = S_RD;
						end
					end else if (cmd_q != CMD_MAP) begin
						res_st_d = ST_NOMAP;
						state_d  = S_DONE;
					end else if (next_pg >= CNT_W'(TABLE_PAGES)) begin
						res_st_d = ST_NOPAGE;
						state_d  = S_DONE;
					end else begin
						npage_d = next_pg[PW-1:0];
						clr_d   = '0;
						state_d = S_PGCLR;
					end
				end else begin
					state_d  = S_DONE;
					res_st_d = ST_OK;
					case (cmd_q)
						CMD_XLATE: begin
							if (rd_data[0]) begin
								res_pa_d = {rd_data[51:12], va_q[11:0]};
							end else begin
								res_st_d = ST_NOMAP;
							end
						end
						CMD_MAP: begin
							mem_we    = 1'b1;
							mem_wdata = {12'd0, pa_q[51:12], 12'd0} | 64'd1 | 64'(flags_q);
						end
						default: begin
							mem_we = 1'b1;
							if (!rd_data[0]) begin
								res_st_d = ST_NOMAP;
							end
						end
					endcase
				end
			end
			S_PGCLR: begin
				mem_we    = 1'b1;
				mem_waddr = {npage_q, clr_q[8:0]};
				clr_d     = clr_q + 1'b1;
				if (clr_q[8:0] == 9'h1FF) begin
					state_d = S_LINK;
				end
			end
			S_LINK: begin
				// parent entry written after the clear, so a reused page keeps it
				mem_we    = 1'b1;
				mem_wdata = {12'd0, new_frame, 12'd0} | 64'd3 | {61'd0, flags_q[2], 2'd0};
				used_d    = used_q + 1'b1;
				page_d    = npage_q;
				lv_d      = lv_q + 1'b1;
				state_d   = S_RD;
			end
			S_DONE: begin
				if (!out_valid || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_q     <= '0;
			used_q    <= '0;
			base_q    <= '0;
			root_q    <= '0;
			alloc_q   <= 7'd1;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			used_q  <= used_d;
			if (cfg_we) begin
				case (cfg_idx)
					REG_BASE:  base_q  <= cfg_data;
					REG_ROOT:  root_q  <= cfg_data[5:0];
					REG_ALLOC: alloc_q <= cfg_data[6:0];
					default:   ;
				endcase
			end
			if (state_q == S_DONE && (!out_valid || out_ready)) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		lv_q     <= lv_d;
		page_q   <= page_d;
		npage_q  <= npage_d;
		res_st_q <= res_st_d;
		res_pa_q <= res_pa_d;
		if (in_valid && in_ready) begin
			cmd_q   <= cmd;
			va_q    <= virt_addr;
			pa_q    <= phys_addr;
			flags_q <= entry_flags;
		end
		if (state_q == S_DONE && (!out_valid || out_ready)) begin
			status      <= res_st_q;
			phys_result <= res_pa_q;
		end
	end

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(TABLE_PAGES))
		else $error("more table pages handed out than the store holds");

	a_result_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && phys_result != '0) |-> status == ST_OK)
		else $error("nonzero address with a failing status");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_DONE) |-> !mem_we)
		else $error("table store written outside a command");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !out_valid) |=> out_valid)
		else $error("finished result not presented");

endmodule
